[src/xed_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and reference-name tables of the xml entity decoder
package xed_pkg;

    localparam int MAX_TEXT_DEF = 1024;

    localparam int NAME_COUNT = 5;
    localparam int NAME_SLOTS = 6;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;

    localparam logic [6:0] CODE_MAX = 7'h7f;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_AMP     = 3'd1,
        MODE_HASH    = 3'd2,
        MODE_NODIGIT = 3'd3,
        MODE_DIGITS  = 3'd4,
        MODE_NAME    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_EMIT = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       end_of_slice;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_digit;

    typedef struct packed {
        logic       hit;
        logic       done;
        logic [7:0] ch;
        logic [2:0] cur;
        logic [2:0] pos;
    } t_name_step;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_name_start;

    // amp; apos; lt; gt; quot; padded with zero bytes
    localparam logic [7:0] NAME_CHARS [NAME_COUNT][NAME_SLOTS] = '{
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00},
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b, 8'h00},
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00}
    };

    // length including the closing semicolon
    localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{3'd4, 3'd5, 3'd3, 3'd3, 3'd5};

    // decoded character of each name
    localparam logic [7:0] NAME_OUT [NAME_COUNT] = '{8'h26, 8'h27, 8'h3c, 8'h3e, 8'h22};

    function automatic t_digit digit_of(input logic [7:0] b, input logic hex);
        t_digit r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r.ok    = 1'b1;
            r.value = 4'(b - 8'h30);
        end else if (hex && (b inside {[8'h61:8'h66]})) begin
            r.ok    = 1'b1;
            r.value = 4'(b - 8'h57);
        end else if (hex && (b inside {[8'h41:8'h46]})) begin
            r.ok    = 1'b1;
            r.value = 4'(b - 8'h37);
        end
        return r;
    endfunction

    // first name whose leading letter is b
    function automatic t_name_start name_start(input logic [7:0] b);
        t_name_start r;
        r = '0;
        for (int c = NAME_COUNT - 1; c >= 0; c--) begin
            if (NAME_CHARS[c][0] == b) begin
                r.hit = 1'b1;
                r.idx = 3'(c);
            end
        end
        return r;
    endfunction

    // next step inside a name; candidates sharing the matched prefix may take over
    function automatic t_name_step name_step(input logic [2:0] cur, input logic [2:0] pos,
                                             input logic [7:0] b);
        t_name_step r;
        logic       same;
        r    = '0;
        same = 1'b0;
        if (cur < 3'(NAME_COUNT) && pos != 3'd0 && pos <= 3'd4 && b != 8'h00) begin
            for (int c = NAME_COUNT - 1; c >= 0; c--) begin
                // only amp and apos share a prefix, and only the leading letter
                same = (3'(c) == cur) || (pos == 3'd1 && c <= 1 && cur <= 3'd1);
                if (same && NAME_CHARS[c][pos] == b) begin
                    r.hit  = 1'b1;
                    r.done = (3'(pos + 3'd1) == NAME_LEN[c]);
                    r.ch   = NAME_OUT[c];
                    r.cur  = 3'(c);
                    r.pos  = 3'(pos + 3'd1);
                end
            end
        end
        return r;
    endfunction

endpackage

[src/xed_parser.sv]
`timescale 1ns / 1ps
// reference parser: per-slice state registers and the single-step decode
module xed_parser #(
    parameter int MAX_TEXT = xed_pkg::MAX_TEXT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_in_byte,
    input  logic             i_last_byte,
    output logic             o_res_valid,
    output xed_pkg::t_result o_res
);

    localparam int CW = $clog2(MAX_TEXT + 1);

    xed_pkg::t_mode   r_mode, n_mode;
    logic [6:0]       r_code, n_code;
    logic             r_ovf, n_ovf;
    logic             r_hex, n_hex;
    logic [CW-1:0]    r_count, n_count;
    logic             r_drop, n_drop;

    xed_pkg::t_digit     dig;
    xed_pkg::t_name_step nst;
    xed_pkg::t_name_start nsa;
    logic [11:0]      acc;
    logic             acc_ovf;
    logic [6:0]       acc_code;

    always_comb begin
        dig = xed_pkg::digit_of(i_in_byte, r_hex);
        nst = xed_pkg::name_step(r_code[5:3], r_code[2:0], i_in_byte);
        nsa = xed_pkg::name_start(i_in_byte);
        // value times base plus digit, saturating at 127
        if (r_hex) begin
            acc = {1'b0, r_code, 4'b0000};
        end else begin
            acc = {2'b00, r_code, 3'b000} + {4'b0000, r_code, 1'b0};
        end
        acc      = acc + {8'h00, dig.value};
        acc_ovf  = r_ovf || (acc > 12'd127);
        acc_code = acc_ovf ? xed_pkg::CODE_MAX : acc[6:0];
    end

    always_comb begin
        xed_pkg::t_kind   kind;
        logic [7:0]       ch;
        xed_pkg::t_status st;
        n_mode  = r_mode;
        n_code  = r_code;
        n_ovf   = r_ovf;
        n_hex   = r_hex;
        n_count = r_count;
        n_drop  = r_drop;
        kind    = xed_pkg::KIND_NONE;
        ch      = 8'h00;
        st      = xed_pkg::ST_OK;
        o_res_valid = 1'b0;
        o_res   = '0;
        if (i_fire) begin
            if (r_drop) begin
                if (i_last_byte) begin
                    n_mode  = xed_pkg::MODE_IDLE;
                    n_code  = '0;
                    n_ovf   = 1'b0;
                    n_hex   = 1'b0;
                    n_count = '0;
                    n_drop  = 1'b0;
                end
            end else begin
                case (r_mode)
                    xed_pkg::MODE_IDLE: begin
                        if (i_in_byte == xed_pkg::CH_AMP) begin
                            n_mode = xed_pkg::MODE_AMP;
                        end else begin
                            kind = xed_pkg::KIND_EMIT;
                            ch   = i_in_byte;
                        end
                    end
                    xed_pkg::MODE_AMP: begin
                        if (i_in_byte == xed_pkg::CH_HASH) begin
                            n_mode = xed_pkg::MODE_HASH;
                        end else if (nsa.hit) begin
                            n_mode = xed_pkg::MODE_NAME;
                            n_code = {1'b0, nsa.idx, 3'd1};
                        end else begin
                            kind = xed_pkg::KIND_BAD;
                        end
                    end
                    xed_pkg::MODE_HASH, xed_pkg::MODE_NODIGIT: begin
                        if (r_mode == xed_pkg::MODE_HASH &&
                            (i_in_byte == xed_pkg::CH_LX || i_in_byte == xed_pkg::CH_UX)) begin
                            n_hex  = 1'b1;
                            n_mode = xed_pkg::MODE_NODIGIT;
                        end else if (dig.ok) begin
                            n_ovf  = acc_ovf;
                            n_code = acc_code;
                            n_mode = xed_pkg::MODE_DIGITS;
                        end else begin
                            kind = xed_pkg::KIND_BAD;
                        end
                    end
                    xed_pkg::MODE_DIGITS: begin
                        if (i_in_byte == xed_pkg::CH_SEMI) begin
                            if (r_ovf) begin
                                kind = xed_pkg::KIND_BAD;
                            end else begin
                                kind   = xed_pkg::KIND_EMIT;
                                ch     = {1'b0, r_code};
                                n_mode = xed_pkg::MODE_IDLE;
                                n_code = '0;
                                n_ovf  = 1'b0;
                                n_hex  = 1'b0;
                            end
                        end else if (dig.ok) begin
                            n_ovf  = acc_ovf;
                            n_code = acc_code;
                        end else begin
                            kind = xed_pkg::KIND_BAD;
                        end
                    end
                    xed_pkg::MODE_NAME: begin
                        if (!nst.hit) begin
                            kind = xed_pkg::KIND_BAD;
                        end else if (nst.done) begin
                            kind   = xed_pkg::KIND_EMIT;
                            ch     = nst.ch;
                            n_mode = xed_pkg::MODE_IDLE;
                            n_code = '0;
                            n_ovf  = 1'b0;
                            n_hex  = 1'b0;
                        end else begin
                            n_code = {1'b0, nst.cur, nst.pos};
                        end
                    end
                    default: begin
                        kind = xed_pkg::KIND_BAD;
                    end
                endcase

                // open reference at slice end
                if (kind == xed_pkg::KIND_NONE && i_last_byte) begin
                    kind = xed_pkg::KIND_BAD;
                end

                if (kind != xed_pkg::KIND_NONE) begin
                    if (kind == xed_pkg::KIND_BAD) begin
                        st = xed_pkg::ST_INVALID;
                        ch = 8'h00;
                    end else if (r_count >= CW'(MAX_TEXT)) begin
                        st = xed_pkg::ST_LIMIT;
                        ch = 8'h00;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    o_res_valid        = 1'b1;
                    o_res.out_byte     = ch;
                    o_res.status       = st;
                    o_res.end_of_slice = i_last_byte || (st != xed_pkg::ST_OK);
                end

                if (i_last_byte) begin
                    n_mode  = xed_pkg::MODE_IDLE;
                    n_code  = '0;
                    n_ovf   = 1'b0;
                    n_hex   = 1'b0;
                    n_count = '0;
                    n_drop  = 1'b0;
                end else if (st != xed_pkg::ST_OK) begin
                    n_mode = xed_pkg::MODE_IDLE;
                    n_code = '0;
                    n_ovf  = 1'b0;
                    n_hex  = 1'b0;
                    n_drop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= xed_pkg::MODE_IDLE;
            r_code  <= '0;
            r_ovf   <= 1'b0;
            r_hex   <= 1'b0;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_code  <= n_code;
            r_ovf   <= n_ovf;
            r_hex   <= n_hex;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

endmodule

[src/xed_out_stage.sv]
`timescale 1ns / 1ps
// result register with one skid entry, registered stall towards the parser
module xed_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  xed_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output xed_pkg::t_result o_res,
    output logic             o_full
);

    logic             r_main_valid, n_main_valid;
    logic             r_skid_valid, n_skid_valid;
    xed_pkg::t_result r_main, n_main;
    xed_pkg::t_result r_skid, n_skid;
    logic             take;

    always_comb begin
        take         = r_main_valid && !i_stall;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (take) begin
            n_main_valid = 1'b0;
        end
        if (r_skid_valid) begin
            // no new word arrives while the skid entry is full
            if (take) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_main_valid || take) begin
                n_main       = i_res;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign o_full  = r_skid_valid;

endmodule

[src/xml_entity_decoder_core.sv]
`timescale 1ns / 1ps
// xml character entity reference decoder, top level
//
// decodes one xml text or attribute slice a byte at a time, one input word per
// clock while o_stall is low: plain bytes pass through, &#N; &#xH; (value up to
// 127) and the names amp lt gt quot apos turn into one byte, anything else
// inside a reference or a reference left open at the slice end reports an
// invalid status, and a byte beyond MAX_TEXT per slice reports the limit
// status; after an error the rest of the slice is swallowed and the error word
// carries end_of_slice. each input word produces zero or one output word; the
// parser state is updated in the cycle the word is taken and the result is
// registered in the output register, or in the skid entry while that register
// is stalled. a single skid entry behind the output register absorbs a
// downstream stall, and o_stall is raised only while that entry is occupied
module xml_entity_decoder_core #(
    parameter int MAX_TEXT = xed_pkg::MAX_TEXT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_end_of_slice
);

    logic             fire;
    logic             res_valid;
    logic             full;
    xed_pkg::t_result res;
    xed_pkg::t_result out_res;

    // a word is taken whenever the skid entry is free
    assign o_stall = full;
    assign fire    = i_valid && !full;

    xed_parser #(
        .MAX_TEXT (MAX_TEXT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    xed_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_full      (full)
    );

    // result fields onto the ports
    assign o_out_byte     = out_res.out_byte;
    assign o_status       = out_res.status;
    assign o_end_of_slice = out_res.end_of_slice;

endmodule

[src/xed_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the xml entity decoder and their binding
module xed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_in_byte,
    input logic       i_last_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_status,
    input logic       o_end_of_slice
);

    // an error word always closes its slice
    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != xed_pkg::ST_OK) |-> o_end_of_slice)
        else $error("error word without end of slice");

    // an error word carries a zero byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != xed_pkg::ST_OK) |-> (o_out_byte == 8'h00))
        else $error("error word with nonzero byte");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte) && $stable(o_status)
                                  && $stable(o_end_of_slice)))
        else $error("stalled output word changed");

endmodule

bind xml_entity_decoder_core xed_checker u_xed_checker (.*);
